FILE: src/ssc_pkg.sv
// ssc_pkg: shared widths, constants and the controller/datapath command and status structs
// for subset_sum_count. No dependencies.
`timescale 1ns / 1ps
package ssc_pkg;
  localparam int unsigned MaxElements = 16;
  localparam int unsigned ValueW      = 20;
  localparam int unsigned TargetW     = 26;
  localparam int unsigned CountW      = 16;
  localparam int unsigned SumW        = 27;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic store;     // write value at the load pointer
    logic clr_load;  // restart element loading
    logic bld_init;  // begin building a table
    logic bld_half;  // 0: first half, 1: second half
    logic bld_step;  // advance the table build by one step
    logic mat_init;  // begin matching
    logic mat_step;  // compare one pair
  } ctrl_t;

  typedef struct packed {
    logic bld_done;
    logic mat_done;
  } stat_t;
endpackage

FILE: src/ssc_datapath.sv
// ssc_datapath: element store, two subset-sum memories, build and match counters,
// and the saturating pair counter. Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_datapath #(
  parameter int unsigned MaxElements = ssc_pkg::MaxElements
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssc_pkg::ctrl_t                    ctrl_i,
  output ssc_pkg::stat_t                    stat_o,
  input  logic signed [ssc_pkg::ValueW-1:0] value_i,
  input  logic signed [ssc_pkg::TargetW-1:0] target_i,
  output logic [ssc_pkg::CountW-1:0]        match_count_o
);
  localparam int unsigned CntW  = $clog2(MaxElements + 1);
  localparam int unsigned IdxW  = $clog2(MaxElements);
  localparam int unsigned HalfN = (MaxElements + 1) / 2;
  localparam int unsigned HalfW = $clog2(HalfN + 1);
  localparam int unsigned AddrW = HalfN;
  localparam int unsigned Depth = 1 << HalfN;
  localparam int unsigned SW    = ssc_pkg::SumW;

  logic signed [ssc_pkg::ValueW-1:0] elem_mem [MaxElements];
  logic signed [SW-1:0] a_mem [Depth];
  logic signed [SW-1:0] b_mem [Depth];

  logic [CntW-1:0] n_q;
  logic [HalfW-1:0] a_cnt, b_cnt, k_q, lim;
  logic [AddrW:0] m_q, i_q, j_q;
  logic [CntW-1:0] eidx;
  logic signed [ssc_pkg::ValueW-1:0] elem_q;
  logic signed [SW-1:0] rd_q, ra_q, rb_q;
  logic mvalid_q;
  logic pair_skip_q;
  logic [ssc_pkg::CountW-1:0] cnt_q;
  logic [AddrW:0] bit_w, a_sz, b_sz;
  logic bphase_q;

  assign a_cnt = HalfW'(n_q >> 1);
  assign b_cnt = HalfW'(n_q - CntW'(a_cnt));
  assign lim   = ctrl_i.bld_half ? b_cnt : a_cnt;
  assign bit_w = (AddrW+1)'(1) << k_q;
  assign a_sz  = (AddrW+1)'(1) << a_cnt;
  assign b_sz  = (AddrW+1)'(1) << b_cnt;
  assign eidx  = ctrl_i.bld_half ? CntW'(a_cnt) + CntW'(k_q) : CntW'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (ctrl_i.clr_load) begin
      n_q <= '0;
    end else if (ctrl_i.store && n_q < CntW'(MaxElements)) begin
      n_q <= n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store && n_q < CntW'(MaxElements)) begin
      elem_mem[n_q[IdxW-1:0]] <= value_i;
    end
  end

  // Build: entry m|bit = entry m + element k. Each entry takes a read phase and a write
  // phase; the read of entry m and the element fetch are issued in the cycle before the write.
  logic [AddrW:0] rm;
  logic bvalid_q;
  logic [AddrW:0] wm_q;
  logic [HalfW-1:0] wk_q;
  assign rm = m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0; m_q <= '0; bvalid_q <= 1'b0; bphase_q <= 1'b0;
    end else if (ctrl_i.bld_init) begin
      k_q <= '0; m_q <= '0; bvalid_q <= 1'b0; bphase_q <= 1'b1;
    end else if (ctrl_i.bld_step) begin
      bvalid_q <= bphase_q && (k_q < lim);
      if (bphase_q) begin
        // issue read of entry m for level k
        if (k_q < lim) begin
          bphase_q <= 1'b0;
        end
      end else begin
        // write done this cycle; advance
        bphase_q <= 1'b1;
        if (m_q + 1'b1 == bit_w) begin
          m_q <= '0; k_q <= k_q + 1'b1;
        end else begin
          m_q <= m_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wm_q <= m_q;
    wk_q <= k_q;
    if (m_q == '0) rd_q <= '0;
    else if (ctrl_i.bld_half) rd_q <= b_mem[rm[AddrW-1:0]];
    else rd_q <= a_mem[rm[AddrW-1:0]];
    elem_q <= elem_mem[eidx[IdxW-1:0]];
    if (ctrl_i.bld_step && bvalid_q) begin
      if (ctrl_i.bld_half) b_mem[AddrW'(wm_q | ((AddrW+1)'(1) << wk_q))]
          <= rd_q + SW'(elem_q);
      else a_mem[AddrW'(wm_q | ((AddrW+1)'(1) << wk_q))] <= rd_q + SW'(elem_q);
    end
  end

  assign stat_o.bld_done = ctrl_i.bld_step && bphase_q && !(k_q < lim);

  // Match: walk all pairs, one read per table per cycle, compare in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; j_q <= '0; mvalid_q <= 1'b0; cnt_q <= '0; pair_skip_q <= 1'b0;
    end else if (ctrl_i.mat_init) begin
      i_q <= '0; j_q <= '0; mvalid_q <= 1'b0; cnt_q <= '0;
    end else if (ctrl_i.mat_step) begin
      mvalid_q <= i_q < a_sz;
      pair_skip_q <= (i_q == '0) && (j_q == '0);
      if (i_q < a_sz) begin
        if (j_q + 1'b1 == b_sz) begin
          j_q <= '0; i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (mvalid_q && !pair_skip_q && ra_q + rb_q == SW'(target_i)
          && cnt_q != ssc_pkg::CountMax) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= (i_q == '0) ? '0 : a_mem[i_q[AddrW-1:0]];
    rb_q <= (j_q == '0) ? '0 : b_mem[j_q[AddrW-1:0]];
  end

  assign stat_o.mat_done = ctrl_i.mat_step && !(i_q < a_sz) && !mvalid_q;
  assign match_count_o = cnt_q;
endmodule

FILE: src/ssc_ctrl.sv
// ssc_ctrl: sequencer for load, build of both tables, match and emit.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           last_i,
  output logic           busy_o,
  output ssc_pkg::ctrl_t ctrl_o,
  input  ssc_pkg::stat_t stat_i,
  output logic           done_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_BUILD_A, ST_BUILD_B, ST_MATCH, ST_EMIT
  } state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE:    if (start_i && last_i) state_q <= ST_BUILD_A;
        ST_BUILD_A: if (stat_i.bld_done) state_q <= ST_BUILD_B;
        ST_BUILD_B: if (stat_i.bld_done) state_q <= ST_MATCH;
        ST_MATCH:   if (stat_i.mat_done) state_q <= ST_EMIT;
        ST_EMIT:    state_q <= ST_IDLE;
        default:    state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.store    = (state_q == ST_IDLE) && start_i;
    ctrl_o.bld_init = ((state_q == ST_IDLE) && start_i && last_i)
                   || ((state_q == ST_BUILD_A) && stat_i.bld_done);
    ctrl_o.bld_half = (state_q == ST_BUILD_B);
    ctrl_o.bld_step = (state_q == ST_BUILD_A) || (state_q == ST_BUILD_B);
    ctrl_o.mat_init = (state_q == ST_BUILD_B) && stat_i.bld_done;
    ctrl_o.mat_step = (state_q == ST_MATCH);
    ctrl_o.clr_load = (state_q == ST_EMIT);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_EMIT);
endmodule

FILE: src/subset_sum_count.sv
// subset_sum_count: top level; ties the sequencer to the datapath and holds target_sum.
// Depends on ssc_pkg, ssc_ctrl, ssc_datapath.
//
// Elements load one per cycle while busy is low. The item with last high starts the
// count: each subset-sum table is built with a read phase and a write phase per entry
// (one memory port per table), then every pair of entries is compared at one pair per
// cycle, then done_o pulses for one cycle with match_count_o. The receiver cannot stall:
// take the count in that cycle.
`timescale 1ns / 1ps
module subset_sum_count #(
  parameter int unsigned MAX_ELEMENTS = ssc_pkg::MaxElements
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ssc_pkg::ValueW-1:0]  value_i,
  input  logic                               last_i,
  output logic                               done_o,
  output logic [ssc_pkg::CountW-1:0]         match_count_o,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [ssc_pkg::TargetW-1:0] target_sum_i
);
  ssc_pkg::ctrl_t ctrl;
  ssc_pkg::stat_t stat;
  logic signed [ssc_pkg::TargetW-1:0] target_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target_q <= target_sum_i;
    end
  end

  ssc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .last_i, .busy_o(busy),
    .ctrl_o(ctrl), .stat_i(stat), .done_o
  );

  ssc_datapath #(.MaxElements(MAX_ELEMENTS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .value_i,
    .target_i(target_q), .match_count_o
  );
endmodule
